/* rtl/brol_pkg.sv */
`timescale 1ns / 1ps

package brol_pkg;

    // default geometry of the ownership table
    localparam int DEF_VOLUMES           = 256;
    localparam int DEF_BLOCKS_PER_VOLUME = 4096;
    localparam int DEF_WORD_BITS         = 64;

    // field widths of one transaction
    localparam int KIND_W   = 2;
    localparam int VOL_W    = 8;
    localparam int START_W  = 12;
    localparam int COUNT_W  = 13;
    localparam int STATUS_W = 2;

    // packed stream widths, tdata rounded up to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;

    // item kinds
    localparam kind_t KIND_ACQUIRE = 2'd0;
    localparam kind_t KIND_RELEASE = 2'd1;
    localparam kind_t KIND_CREATE  = 2'd2;
    localparam kind_t KIND_DELETE  = 2'd3;

    // result codes
    localparam status_t ST_DONE     = 2'd0;
    localparam status_t ST_CONFLICT = 2'd1;
    localparam status_t ST_RANGE    = 2'd2;
    localparam status_t ST_BADVOL   = 2'd3;

endpackage

/* rtl/block_range_ownership_lock.sv */
`timescale 1ns / 1ps

// channel | direction | tdata (lowest bit up)                    | tuser
// s_      | in        | volume[7:0] start_block[19:8]            | kind[1:0]
//         |           | block_count[32:20], zero fill to 40 bits |
// m_      | out       | status[1:0], zero fill to 8 bits         | -
//
// an acquire checks and then writes each bitmap word in the range, a release only
//   writes them; a conflict ends the check pass early; create on an empty volume
//   clears every bitmap word of that volume
// reset: aresetn low for one edge, then a sweep over every volume zeroes the size memory
// stalls: one result register; the next transaction is taken while it waits, but it
//   cannot finish until the result is taken
module block_range_ownership_lock #(
    parameter int VOLUMES           = brol_pkg::DEF_VOLUMES,
    parameter int BLOCKS_PER_VOLUME = brol_pkg::DEF_BLOCKS_PER_VOLUME,
    parameter int WORD_BITS         = brol_pkg::DEF_WORD_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // volume, start_block, block_count
    input  logic [brol_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic [brol_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status
    output logic [brol_pkg::M_TDATA_W-1:0] m_tdata
);
    import brol_pkg::*;

    localparam int WPV        = (BLOCKS_PER_VOLUME + WORD_BITS - 1) / WORD_BITS;
    localparam int VOL_AW     = (VOLUMES > 1) ? $clog2(VOLUMES) : 1;
    localparam int AW         = (VOLUMES * WPV > 1) ? $clog2(VOLUMES * WPV) : 1;
    localparam int WPV_W      = (WPV > 1) ? $clog2(WPV) : 1;
    localparam int LO_W       = $clog2(WORD_BITS);
    localparam int DIV_SHIFT  = 20;
    localparam int RECIP      = (1 << DIV_SHIFT) / WORD_BITS;

    // sequencer states
    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_SIZE = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_REM  = 4'd4;
    localparam logic [3:0] S_RD   = 4'd5;
    localparam logic [3:0] S_MOD  = 4'd6;
    localparam logic [3:0] S_CLR  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    // storage
    logic [COUNT_W-1:0]   size_mem [VOLUMES];
    logic [WORD_BITS-1:0] word_mem [VOLUMES * WPV];

    logic [3:0]           state_reg, state_next;
    kind_t                kind_reg;
    logic [VOL_W-1:0]     vol_reg;
    logic [START_W-1:0]   start_reg;
    logic [COUNT_W-1:0]   count_reg;
    status_t              status_reg, status_next;
    logic [AW-1:0]        base_reg, base_next;
    logic [START_W-1:0]   q_reg, q_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [AW-1:0]        first_addr_reg, first_addr_next;
    logic [LO_W-1:0]      lo_reg, lo_next;
    logic [LO_W-1:0]      first_lo_reg, first_lo_next;
    logic [COUNT_W-1:0]   remain_reg, remain_next;
    logic                 set_pass_reg, set_pass_next;
    logic [WPV_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [VOL_AW-1:0]    init_cnt_reg, init_cnt_next;
    logic [COUNT_W-1:0]   size_rd_reg;
    logic [WORD_BITS-1:0] word_rd_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    status_t              m_status_reg, m_status_next;

    logic                 s_accept;
    logic [VOL_AW-1:0]    in_vol_idx;
    logic [VOL_AW-1:0]    vol_idx;
    logic                 vol_bad;
    logic [COUNT_W:0]     end_blk;
    logic                 count_big;
    logic [COUNT_W-1:0]   rem0, rem1;
    logic [START_W-1:0]   q1;
    int                   avail;
    int                   take;
    int                   hi;
    logic [COUNT_W-1:0]   take_w;
    logic                 last_word;
    logic [WORD_BITS-1:0] mask;
    logic                 out_load;

    logic                 size_we;
    logic [VOL_AW-1:0]    size_waddr;
    logic [COUNT_W-1:0]   size_wdata;
    logic                 word_we;
    logic [AW-1:0]        word_waddr;
    logic [WORD_BITS-1:0] word_wdata;

    assign s_tready   = (state_reg == S_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign in_vol_idx = VOL_AW'(s_tdata[VOL_W-1:0]);
    assign vol_idx    = VOL_AW'(vol_reg);
    assign vol_bad    = int'(vol_reg) >= VOLUMES;
    assign end_blk    = (COUNT_W+1)'(start_reg) + (COUNT_W+1)'(count_reg);
    assign count_big  = int'(count_reg) > BLOCKS_PER_VOLUME;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = M_TDATA_W'(m_status_reg);

    // start_block split into word and bit offset: reciprocal quotient plus one fix-up
    always_comb begin
        rem0 = COUNT_W'(start_reg) - COUNT_W'(int'(q_reg) * WORD_BITS);
        if (int'(rem0) >= WORD_BITS) begin
            q1   = q_reg + START_W'(1);
            rem1 = rem0 - COUNT_W'(WORD_BITS);
        end else begin
            q1   = q_reg;
            rem1 = rem0;
        end
    end

    // bits of the range that fall in the current word
    always_comb begin
        avail = WORD_BITS - int'(lo_reg);
        take  = (int'(remain_reg) < avail) ? int'(remain_reg) : avail;
        hi    = int'(lo_reg) + take;
        for (int i = 0; i < WORD_BITS; i++) begin
            mask[i] = (i >= int'(lo_reg)) && (i < hi);
        end
    end
    assign take_w    = COUNT_W'(take);
    assign last_word = (remain_reg == take_w);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        status_next     = status_reg;
        base_next       = base_reg;
        q_next          = q_reg;
        addr_next       = addr_reg;
        first_addr_next = first_addr_reg;
        lo_next         = lo_reg;
        first_lo_next   = first_lo_reg;
        remain_next     = remain_reg;
        set_pass_next   = set_pass_reg;
        clr_cnt_next    = clr_cnt_reg;
        init_cnt_next   = init_cnt_reg;
        size_we         = 1'b0;
        size_waddr      = vol_idx;
        size_wdata      = '0;
        word_we         = 1'b0;
        word_waddr      = addr_reg;
        word_wdata      = '0;
        out_load        = 1'b0;

        unique case (state_reg)
            S_INIT: begin
                size_we    = 1'b1;
                size_waddr = init_cnt_reg;
                if (init_cnt_reg == VOL_AW'(VOLUMES - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    init_cnt_next = init_cnt_reg + VOL_AW'(1);
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_SIZE;
                end
            end
            S_SIZE: begin
                base_next    = AW'(int'(vol_idx) * WPV);
                clr_cnt_next = '0;
                status_next  = ST_DONE;
                state_next   = S_FIN;
                if (vol_bad) begin
                    status_next = ST_BADVOL;
                end else begin
                    case (kind_reg)
                        KIND_ACQUIRE, KIND_RELEASE: begin
                            if (end_blk > (COUNT_W+1)'(size_rd_reg)) begin
                                status_next = ST_RANGE;
                            end else if (count_reg != '0) begin
                                state_next = S_DIV;
                            end
                        end
                        KIND_CREATE: begin
                            if (count_reg == '0) begin
                                size_we = 1'b1;
                            end else if (count_big) begin
                                status_next = ST_RANGE;
                            end else if (size_rd_reg == '0) begin
                                state_next = S_CLR;
                            end
                        end
                        default: begin
                            size_we = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV: begin
                q_next     = START_W'((int'(start_reg) * RECIP) >> DIV_SHIFT);
                state_next = S_REM;
            end
            S_REM: begin
                addr_next       = base_reg + AW'(q1);
                first_addr_next = base_reg + AW'(q1);
                lo_next         = LO_W'(rem1);
                first_lo_next   = LO_W'(rem1);
                remain_next     = count_reg;
                set_pass_next   = (kind_reg == KIND_RELEASE);
                state_next      = S_RD;
            end
            S_RD: begin
                state_next = S_MOD;
            end
            S_MOD: begin
                state_next = S_RD;
                if (!set_pass_reg) begin
                    // check pass of an acquire
                    if ((word_rd_reg & mask) != '0) begin
                        status_next = ST_CONFLICT;
                        state_next  = S_FIN;
                    end else if (last_word) begin
                        set_pass_next = 1'b1;
                        addr_next     = first_addr_reg;
                        lo_next       = first_lo_reg;
                        remain_next   = count_reg;
                    end else begin
                        addr_next   = addr_reg + AW'(1);
                        lo_next     = '0;
                        remain_next = remain_reg - take_w;
                    end
                end else begin
                    word_we    = 1'b1;
                    word_wdata = (kind_reg == KIND_ACQUIRE) ? (word_rd_reg | mask)
                                                            : (word_rd_reg & ~mask);
                    if (last_word) begin
                        status_next = ST_DONE;
                        state_next  = S_FIN;
                    end else begin
                        addr_next   = addr_reg + AW'(1);
                        lo_next     = '0;
                        remain_next = remain_reg - take_w;
                    end
                end
            end
            S_CLR: begin
                word_we    = 1'b1;
                word_waddr = base_reg + AW'(clr_cnt_reg);
                if (clr_cnt_reg == WPV_W'(WPV - 1)) begin
                    size_we     = 1'b1;
                    size_wdata  = count_reg;
                    status_next = ST_DONE;
                    state_next  = S_FIN;
                end else begin
                    clr_cnt_next = clr_cnt_reg + WPV_W'(1);
                end
            end
            S_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register
    always_comb begin
        m_status_next = m_status_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_status_next = status_reg;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            init_cnt_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
            set_pass_reg  <= 1'b0;
            clr_cnt_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
            set_pass_reg  <= set_pass_next;
            clr_cnt_reg   <= clr_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg  <= kind_t'(s_tuser[KIND_W-1:0]);
            vol_reg   <= s_tdata[VOL_W-1:0];
            start_reg <= s_tdata[VOL_W +: START_W];
            count_reg <= s_tdata[VOL_W+START_W +: COUNT_W];
        end
        status_reg     <= status_next;
        base_reg       <= base_next;
        q_reg          <= q_next;
        addr_reg       <= addr_next;
        first_addr_reg <= first_addr_next;
        lo_reg         <= lo_next;
        first_lo_reg   <= first_lo_next;
        remain_reg     <= remain_next;
        m_status_reg   <= m_status_next;
    end

    // volume size memory, read as the transaction is taken
    always_ff @(posedge aclk) begin
        if (size_we) begin
            size_mem[size_waddr] <= size_wdata;
        end
        size_rd_reg <= size_mem[in_vol_idx];
    end

    // ownership bitmap; a volume's words are zeroed by create before any range
    // can reach them, so the bitmap itself needs no reset
    always_ff @(posedge aclk) begin
        if (word_we) begin
            word_mem[word_waddr] <= word_wdata;
        end
        if (state_reg == S_RD) begin
            word_rd_reg <= word_mem[addr_reg];
        end
    end

    // a taken transaction always goes on to the size lookup
    a_accept_to_size: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == S_SIZE)
        else $error("transaction taken without size lookup");

    // a conflict can only come from the check pass of an acquire
    a_conflict_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MOD && status_next == ST_CONFLICT && status_reg != ST_CONFLICT)
        |-> (kind_reg == KIND_ACQUIRE && !set_pass_reg))
        else $error("conflict outside acquire check pass");

    // the bitmap is written only on write-back or clearing sweep
    a_word_we: assert property (@(posedge aclk) disable iff (!aresetn)
        word_we |-> (state_reg == S_CLR || (state_reg == S_MOD && set_pass_reg)))
        else $error("bitmap written outside write pass");

    // a word visit always has blocks left to cover
    a_remain: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MOD |-> remain_reg != '0 && take_w != '0)
        else $error("word visited with empty range");

endmodule

/* dv/block_range_ownership_lock_tb.sv */
`timescale 1ns / 1ps

module block_range_ownership_lock_tb;
    import brol_pkg::*;

    localparam int VOLS       = DEF_VOLUMES;
    localparam int VOL_BLOCKS = DEF_BLOCKS_PER_VOLUME;
    localparam int TAIL_WAIT  = 300;

    // expected behaviour of the ownership table and the store of pending statuses
    class ownership_table;
        logic [COUNT_W-1:0]  vol_size [VOLS];
        bit [VOL_BLOCKS-1:0] owned    [VOLS];
        status_t             pending_status [$];
        int                  fail_count;

        function new();
            foreach (vol_size[v]) begin
                vol_size[v] = '0;
                owned[v]    = '0;
            end
            fail_count = 0;
        endfunction

        // work out the status of an accepted transaction and update the table
        function void apply_item(kind_t kind, logic [VOL_W-1:0] vol,
                                 logic [START_W-1:0] start, logic [COUNT_W-1:0] count);
            status_t st;
            int      last_blk;
            bit      busy;
            st       = ST_DONE;
            last_blk = int'(start) + int'(count);
            busy     = 1'b0;
            if (int'(vol) >= VOLS) begin
                st = ST_BADVOL;
            end else if (kind == KIND_ACQUIRE || kind == KIND_RELEASE) begin
                if (last_blk > int'(vol_size[vol])) begin
                    st = ST_RANGE;
                end else if (kind == KIND_ACQUIRE) begin
                    for (int b = start; b < last_blk; b++)
                        if (owned[vol][b]) busy = 1'b1;
                    if (busy) begin
                        st = ST_CONFLICT;
                    end else begin
                        for (int b = start; b < last_blk; b++) owned[vol][b] = 1'b1;
                    end
                end else begin
                    for (int b = start; b < last_blk; b++) owned[vol][b] = 1'b0;
                end
            end else if (kind == KIND_CREATE) begin
                if (count == 0) begin
                    vol_size[vol] = '0;
                end else if (int'(count) > VOL_BLOCKS) begin
                    st = ST_RANGE;
                end else if (vol_size[vol] == 0) begin
                    owned[vol]    = '0;
                    vol_size[vol] = count;
                end
            end else begin
                vol_size[vol] = '0;
            end
            pending_status.push_back(st);
        endfunction

        // compare a returned status with the oldest expectation
        function void check_status(status_t got);
            status_t want;
            if (pending_status.size() == 0) begin
                $error("status: unexpected result, expected none, actual %0d", got);
                fail_count++;
                return;
            end
            want = pending_status.pop_front();
            if (got !== want) begin
                $error("status: expected %0d, actual %0d", want, got);
                fail_count++;
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // volume, start_block, block_count
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // kind
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // status
    logic [M_TDATA_W-1:0] m_tdata;

    ownership_table book = new();
    bit                   no_idle = 1'b0;
    logic [VOL_W-1:0]     vol_pool [8];

    block_range_ownership_lock u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // idle length, mostly short with the odd long one
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one transaction and hold it until taken
    task automatic send_item(kind_t kind, logic [VOL_W-1:0] vol,
                             logic [START_W-1:0] start, logic [COUNT_W-1:0] count);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, count, start, vol};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        book.apply_item(kind, vol, start, count);
        gap = pick_idle();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // mostly well-formed traffic on a few volumes, the rest random noise
    task automatic send_random_item();
        kind_t kind;
        int    vol, size, start, count, r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            kind  = kind_t'($urandom_range(0, 3));
            vol   = $urandom_range(0, 255);
            start = $urandom_range(0, 4095);
            count = ($urandom_range(0, 19) == 0) ? $urandom_range(4097, 8191)
                                                 : $urandom_range(0, 4096);
        end else begin
            vol   = vol_pool[$urandom_range(0, 7)];
            size  = book.vol_size[vol];
            r     = $urandom_range(0, 99);
            if (size == 0)
                kind = (r < 85) ? KIND_CREATE : kind_t'($urandom_range(0, 3));
            else if (r < 45) kind = KIND_ACQUIRE;
            else if (r < 75) kind = KIND_RELEASE;
            else if (r < 92) kind = KIND_CREATE;
            else             kind = KIND_DELETE;
            start = $urandom_range(0, 4095);
            if (kind == KIND_CREATE) begin
                r = $urandom_range(0, 99);
                if (r < 70)      count = $urandom_range(16, 512);
                else if (r < 90) count = $urandom_range(1, 15);
                else if (r < 95) count = VOL_BLOCKS;
                else             count = $urandom_range(513, VOL_BLOCKS);
            end else if (kind == KIND_DELETE) begin
                count = $urandom_range(0, 4096);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5)       count = 0;
                else if (r < 80) count = $urandom_range(1, 16);
                else if (r < 97) count = $urandom_range(17, 200);
                else             count = $urandom_range(1, VOL_BLOCKS);
                if (count > size) count = size;
                start = $urandom_range(0, size - count);
            end
        end
        send_item(kind, vol[VOL_W-1:0], start[START_W-1:0], count[COUNT_W-1:0]);
    endtask

    // result side: random stalls and one long hold-off to back the block up
    initial begin : result_sink
        int  stall;
        int  seen;
        bit  held;
        stall = 0;
        seen  = 0;
        held  = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) seen++;
            if (!held && seen >= 400) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (500) @(posedge aclk);
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                stall = pick_idle();
            end
        end
    end

    // check every returned status
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            book.check_status(m_tdata[STATUS_W-1:0]);
    end

    // stimulus
    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed corners; a bad volume cannot be addressed with 8-bit ids and 256 volumes
        send_item(KIND_ACQUIRE, 8'd0,   12'd0,    13'd1);    // no volume yet
        send_item(KIND_ACQUIRE, 8'd0,   12'd0,    13'd0);    // empty range at size zero
        send_item(KIND_CREATE,  8'd0,   12'd0,    13'd4096); // full capacity
        send_item(KIND_CREATE,  8'd255, 12'd4095, 13'd1);
        send_item(KIND_CREATE,  8'd0,   12'd0,    13'd100);  // already exists, ignored
        send_item(KIND_CREATE,  8'd7,   12'd0,    13'd4097); // beyond capacity
        send_item(KIND_CREATE,  8'd8,   12'd0,    13'd8191);
        send_item(KIND_ACQUIRE, 8'd0,   12'd0,    13'd4096);
        send_item(KIND_ACQUIRE, 8'd0,   12'd4095, 13'd1);    // conflict
        send_item(KIND_RELEASE, 8'd0,   12'd0,    13'd4096);
        send_item(KIND_ACQUIRE, 8'd0,   12'd4095, 13'd1);
        send_item(KIND_ACQUIRE, 8'd0,   12'd4095, 13'd2);    // one past the end
        send_item(KIND_ACQUIRE, 8'd0,   12'd4095, 13'd4096);
        send_item(KIND_ACQUIRE, 8'd255, 12'd0,    13'd1);
        send_item(KIND_ACQUIRE, 8'd255, 12'd0,    13'd1);    // conflict
        send_item(KIND_RELEASE, 8'd255, 12'd1,    13'd0);    // empty range at the size
        send_item(KIND_ACQUIRE, 8'd255, 12'd2,    13'd0);    // empty range past the size
        send_item(KIND_DELETE,  8'd255, 12'd4095, 13'd4096);
        send_item(KIND_ACQUIRE, 8'd255, 12'd0,    13'd1);
        send_item(KIND_CREATE,  8'd255, 12'd0,    13'd64);   // stale flags must be cleared
        send_item(KIND_ACQUIRE, 8'd255, 12'd0,    13'd64);
        send_item(KIND_CREATE,  8'd0,   12'd0,    13'd0);    // create of zero deletes
        send_item(KIND_ACQUIRE, 8'd0,   12'd0,    13'd1);
        send_item(KIND_DELETE,  8'd100, 12'd0,    13'd0);
        send_item(KIND_RELEASE, 8'd3,   12'd0,    13'd0);

        // random traffic with some stretches free of idling
        vol_pool[0] = 8'd0;
        vol_pool[1] = 8'd255;
        for (int v = 2; v < 8; v++) vol_pool[v] = $urandom_range(0, 255);
        for (int i = 0; i < 1850; i++) begin
            if (i % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
            send_random_item();
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        // drain and let any stray result show up
        while (book.pending_status.size() != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
        if (book.fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
